[design/scht_pkg.sv]
// ----------------------------------------------------------------------------
// scht_pkg
// Shared types, constants and codes for the spatial cell hash table.
// ----------------------------------------------------------------------------
package scht_pkg;

    // Table geometry.
    localparam int TABLE_SIZE   = 256;
    localparam int BUCKET_DEPTH = 16;
    localparam int IDX_W        = $clog2(TABLE_SIZE);
    localparam int SLOTS_W      = IDX_W + 1;
    localparam int BIDX_W       = $clog2(BUCKET_DEPTH);
    localparam int CNT_W        = BIDX_W + 1;
    localparam int KEY_W        = 48;
    localparam int SLOT_W       = KEY_W + CNT_W;
    localparam int MEM_DEPTH    = TABLE_SIZE * BUCKET_DEPTH;

    // Hash primes.
    localparam logic [31:0] HP1 = 32'd961816649;
    localparam logic [31:0] HP2 = 32'd961893937;
    localparam logic [31:0] HP3 = 32'd962228011;

    // Request codes.
    localparam logic [1:0] REQ_INSERT = 2'd0;
    localparam logic [1:0] REQ_LOOKUP = 2'd1;
    localparam logic [1:0] REQ_CLEAR  = 2'd2;

    // Result status codes.
    localparam logic [2:0] ST_OK       = 3'd0;
    localparam logic [2:0] ST_NOTFOUND = 3'd1;
    localparam logic [2:0] ST_TFULL    = 3'd2;
    localparam logic [2:0] ST_BFULL    = 3'd3;
    localparam logic [2:0] ST_CLEARED  = 3'd4;

    // Input item.
    typedef struct packed {
        logic [1:0]         req_type;
        logic signed [15:0] cell_x;
        logic signed [15:0] cell_y;
        logic signed [15:0] cell_z;
        logic [15:0]        item_id;
    } t_req;

    // Result item.
    typedef struct packed {
        logic [15:0] member_id;
        logic [2:0]  status;
        logic        last;
    } t_rsp;

    // Classified request passed from the front to the back.
    typedef struct packed {
        logic [1:0]       req_type;
        logic [KEY_W-1:0] key;
        logic [15:0]      item_id;
        logic [IDX_W-1:0] home;
    } t_qent;

    // Stored slot: cell key and bucket fill.
    typedef struct packed {
        logic [KEY_W-1:0] key;
        logic [CNT_W-1:0] cnt;
    } t_slot;

endpackage

[design/scht_ram.sv]
// ----------------------------------------------------------------------------
// scht_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module scht_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Write port and registered read port.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

[design/scht_front.sv]
// ----------------------------------------------------------------------------
// scht_front
// Accepts items, hashes the cell and reduces the hash to a home slot.
// ----------------------------------------------------------------------------
module scht_front (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_in_valid,
    output logic                          o_in_stall,
    input  scht_pkg::t_req                i_in_data,
    input  logic [scht_pkg::SLOTS_W-1:0]  i_slots,
    output logic                          o_push,
    output scht_pkg::t_qent               o_ent,
    input  logic                          i_full
);

    typedef enum logic [4:0] {
        F_IDLE = 5'b00001,
        F_MUL  = 5'b00010,
        F_SUM  = 5'b00100,
        F_MOD  = 5'b01000,
        F_PUSH = 5'b10000
    } t_fstate;

    t_fstate r_state, n_state;
    scht_pkg::t_req r_item;
    logic [31:0] r_p1, r_p2, r_p3, r_hv;
    logic [scht_pkg::SLOTS_W-1:0] r_rem, n_rem;
    logic [2:0] r_step;

    // Four remainder steps per cycle, most significant hash bits first.
    always_comb begin
        logic [scht_pkg::SLOTS_W:0] v_r;
        logic [3:0] v_bits;
        v_r    = '0;
        v_bits = r_hv[31 - 4*r_step -: 4];
        n_rem  = r_rem;
        for (int b = 0; b < 4; b++) begin
            v_r = {n_rem, v_bits[3-b]};
            if (v_r >= {1'b0, i_slots}) begin
                v_r = v_r - {1'b0, i_slots};
            end
            n_rem = v_r[scht_pkg::SLOTS_W-1:0];
        end
    end

    // Next state.
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            F_IDLE: if (i_in_valid) n_state = F_MUL;
            F_MUL:  n_state = F_SUM;
            F_SUM:  n_state = F_MOD;
            F_MOD:  if (r_step == 3'd7) n_state = F_PUSH;
            F_PUSH: if (!i_full) n_state = F_IDLE;
            default: n_state = F_IDLE;
        endcase
    end

    // Control state.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= F_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Datapath: products, sum, then the iterative remainder.
    always_ff @(posedge i_clk) begin
        if (r_state == F_IDLE && i_in_valid) begin
            r_item <= i_in_data;
        end
        if (r_state == F_MUL) begin
            r_p1 <= 32'(32'(signed'(r_item.cell_x)) * scht_pkg::HP1);
            r_p2 <= 32'(32'(signed'(r_item.cell_y)) * scht_pkg::HP2);
            r_p3 <= 32'(32'(signed'(r_item.cell_z)) * scht_pkg::HP3);
        end
        if (r_state == F_SUM) begin
            r_hv   <= r_p1 + r_p2 + r_p3;
            r_rem  <= '0;
            r_step <= '0;
        end
        if (r_state == F_MOD) begin
            r_rem  <= n_rem;
            r_step <= r_step + 3'd1;
        end
    end

    assign o_in_stall     = (r_state != F_IDLE);
    assign o_push         = (r_state == F_PUSH) && !i_full;
    assign o_ent.req_type = r_item.req_type;
    assign o_ent.key      = {r_item.cell_x, r_item.cell_y, r_item.cell_z};
    assign o_ent.item_id  = r_item.item_id;
    assign o_ent.home     = r_rem[scht_pkg::IDX_W-1:0];

endmodule

[design/scht_queue.sv]
// ----------------------------------------------------------------------------
// scht_queue
// Two-entry queue of classified requests between the front and the back.
// ----------------------------------------------------------------------------
module scht_queue (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_push,
    input  scht_pkg::t_qent i_ent,
    output logic            o_full,
    input  logic            i_pop,
    output logic            o_valid,
    output scht_pkg::t_qent o_ent
);

    scht_pkg::t_qent r_buf [2];
    logic r_wp, r_rp;
    logic [1:0] r_cnt;

    // Pointers and fill.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= '0;
        end else begin
            if (i_push) r_wp <= !r_wp;
            if (i_pop)  r_rp <= !r_rp;
            r_cnt <= r_cnt + {1'b0, i_push} - {1'b0, i_pop};
        end
    end

    // Storage.
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_buf[r_wp] <= i_ent;
        end
    end

    assign o_full  = (r_cnt == 2'd2);
    assign o_valid = (r_cnt != 2'd0);
    assign o_ent   = r_buf[r_rp];

endmodule

[design/scht_back.sv]
// ----------------------------------------------------------------------------
// scht_back
// Probes the table, inserts ids, streams bucket members and clears slots.
// ----------------------------------------------------------------------------
module scht_back (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_q_valid,
    input  scht_pkg::t_qent               i_q_ent,
    output logic                          o_q_pop,
    input  logic [scht_pkg::SLOTS_W-1:0]  i_slots,
    output logic                          o_out_valid,
    input  logic                          i_out_stall,
    output scht_pkg::t_rsp                o_out_data
);

    typedef enum logic [2:0] {
        S_IDLE = 3'b001,
        S_CHK  = 3'b010,
        S_EMIT = 3'b100
    } t_bstate;

    t_bstate r_state, n_state;
    scht_pkg::t_qent r_cur, n_cur;
    logic [scht_pkg::IDX_W-1:0] r_idx, n_idx;
    logic [scht_pkg::SLOTS_W-1:0] r_k, n_k;
    logic [scht_pkg::CNT_W-1:0] r_c, n_c;
    logic [scht_pkg::BIDX_W-1:0] r_bi, n_bi;
    logic [scht_pkg::TABLE_SIZE-1:0] r_vld;
    logic r_out_valid, n_out_valid;
    scht_pkg::t_rsp r_out, n_out;

    scht_pkg::t_slot w_slot_rd, w_slot_wr;
    logic [15:0] w_mem_rd;
    logic w_we, w_clr, w_vld, w_match, w_hit, w_free, w_lap, w_last;
    logic [scht_pkg::CNT_W-1:0] w_cnt;

    // Slot RAM: cell key and bucket fill.
    scht_ram #(.WIDTH(scht_pkg::SLOT_W), .DEPTH(scht_pkg::TABLE_SIZE)) u_slot_ram (
        .i_clk  (i_clk),
        .i_we   (w_we),
        .i_waddr(r_idx),
        .i_wdata(w_slot_wr),
        .i_raddr(n_idx),
        .o_rdata(w_slot_rd)
    );

    // Member RAM: one row of bucket entries per slot.
    scht_ram #(.WIDTH(16), .DEPTH(scht_pkg::MEM_DEPTH)) u_mem_ram (
        .i_clk  (i_clk),
        .i_we   (w_we),
        .i_waddr({r_idx, w_cnt[scht_pkg::BIDX_W-1:0]}),
        .i_wdata(r_cur.item_id),
        .i_raddr({r_idx, n_bi}),
        .o_rdata(w_mem_rd)
    );

    // Probe classification of the slot now read.
    assign w_vld   = r_vld[r_idx];
    assign w_cnt   = w_vld ? w_slot_rd.cnt : '0;
    assign w_match = w_vld && (w_slot_rd.key == r_cur.key);
    assign w_hit   = !w_vld || w_match;
    assign w_free  = !r_out_valid || !i_out_stall;
    assign w_lap   = ((r_k + scht_pkg::SLOTS_W'(1)) == i_slots);
    assign w_last  = ({1'b0, r_bi} + scht_pkg::CNT_W'(1)) == r_c;
    assign w_slot_wr.key = r_cur.key;
    assign w_slot_wr.cnt = w_cnt + scht_pkg::CNT_W'(1);

    // Sequencer.
    always_comb begin
        n_state     = r_state;
        n_cur       = r_cur;
        n_idx       = r_idx;
        n_k         = r_k;
        n_c         = r_c;
        n_bi        = r_bi;
        n_out_valid = r_out_valid && i_out_stall;
        n_out       = r_out;
        o_q_pop     = 1'b0;
        w_we        = 1'b0;
        w_clr       = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                if (i_q_valid && w_free) begin
                    o_q_pop = 1'b1;
                    n_cur   = i_q_ent;
                    unique case (i_q_ent.req_type)
                        scht_pkg::REQ_CLEAR: begin
                            w_clr       = 1'b1;
                            n_out_valid = 1'b1;
                            n_out       = '{16'd0, scht_pkg::ST_CLEARED, 1'b1};
                        end
                        scht_pkg::REQ_INSERT, scht_pkg::REQ_LOOKUP: begin
                            n_idx   = i_q_ent.home;
                            n_k     = '0;
                            n_state = S_CHK;
                        end
                        default: ;
                    endcase
                end
            end
            S_CHK: begin
                if (w_free) begin
                    if (w_hit) begin
                        n_state = S_IDLE;
                        n_bi    = '0;
                        if (r_cur.req_type == scht_pkg::REQ_INSERT) begin
                            n_out_valid = 1'b1;
                            if (w_cnt >= scht_pkg::CNT_W'(scht_pkg::BUCKET_DEPTH)) begin
                                n_out = '{r_cur.item_id, scht_pkg::ST_BFULL, 1'b1};
                            end else begin
                                w_we  = 1'b1;
                                n_out = '{r_cur.item_id, scht_pkg::ST_OK, 1'b1};
                            end
                        end else if (w_cnt == '0) begin
                            n_out_valid = 1'b1;
                            n_out       = '{16'd0, scht_pkg::ST_NOTFOUND, 1'b1};
                        end else begin
                            n_c     = w_cnt;
                            n_state = S_EMIT;
                        end
                    end else if (w_lap) begin
                        n_state     = S_IDLE;
                        n_out_valid = 1'b1;
                        if (r_cur.req_type == scht_pkg::REQ_INSERT) begin
                            n_out = '{r_cur.item_id, scht_pkg::ST_TFULL, 1'b1};
                        end else begin
                            n_out = '{16'd0, scht_pkg::ST_NOTFOUND, 1'b1};
                        end
                    end else begin
                        n_k = r_k + scht_pkg::SLOTS_W'(1);
                        if (({1'b0, r_idx} + scht_pkg::SLOTS_W'(1)) == i_slots) begin
                            n_idx = '0;
                        end else begin
                            n_idx = r_idx + scht_pkg::IDX_W'(1);
                        end
                    end
                end
            end
            S_EMIT: begin
                if (w_free) begin
                    n_out_valid = 1'b1;
                    n_out       = '{w_mem_rd, scht_pkg::ST_OK, w_last};
                    if (w_last) begin
                        n_state = S_IDLE;
                    end else begin
                        n_bi = r_bi + scht_pkg::BIDX_W'(1);
                    end
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // Control state and slot valid bits.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
            r_vld       <= '0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
            if (w_clr) begin
                r_vld <= '0;
            end else if (w_we) begin
                r_vld[r_idx] <= 1'b1;
            end
        end
    end

    // Working registers and the output register.
    always_ff @(posedge i_clk) begin
        r_cur <= n_cur;
        r_idx <= n_idx;
        r_k   <= n_k;
        r_c   <= n_c;
        r_bi  <= n_bi;
        r_out <= n_out;
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

endmodule

[design/spatial_cell_hash_table.sv]
// ----------------------------------------------------------------------------
// spatial_cell_hash_table
// Linear-probing hash table of 3-D grid cells with per-cell buckets of ids.
// ----------------------------------------------------------------------------
//  Channel  Direction  Handshake                  Payload
//  in       input      i_in_valid / o_in_stall    i_in_data  (t_req)
//  out      output     o_out_valid / i_out_stall  o_out_data (t_rsp)
//  cfg      input      APB psel/penable/pwrite    table_slots at address 0
//
//  The front takes a new item only while idle: it accepts the item, forms
//  the three products, sums them, reduces the sum with a 4-bit-per-cycle
//  remainder unit and pushes the entry into the queue when it is not full.
//  The back takes a request from the queue, then probes one slot at a time,
//  and on a lookup hit streams the bucket members; it holds while out stalls.
//  Reset clears the slot valid bits at once; no clearing pass is needed.
//  Either side may stall; the two-entry queue and the output register keep
//  the front and the back running independently.
// ----------------------------------------------------------------------------
module spatial_cell_hash_table (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_in_valid,
    output logic           o_in_stall,
    input  scht_pkg::t_req i_in_data,
    output logic           o_out_valid,
    input  logic           i_out_stall,
    output scht_pkg::t_rsp o_out_data,
    input  logic           psel,
    input  logic           penable,
    input  logic           pwrite,
    input  logic [2:0]     paddr,
    input  logic [31:0]    pwdata,
    output logic [31:0]    prdata,
    output logic           pready
);

    logic [8:0] r_table_slots;
    logic [scht_pkg::SLOTS_W-1:0] w_slots;
    logic w_push, w_full, w_pop, w_q_valid;
    scht_pkg::t_qent w_f_ent, w_q_ent;

    // Configuration register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_table_slots <= 9'd256;
        end else if (psel && penable && pwrite && !paddr[2]) begin
            r_table_slots <= pwdata[8:0];
        end
    end

    assign pready = 1'b1;
    assign prdata = paddr[2] ? 32'd0 : {23'd0, r_table_slots};

    // Slots in use, saturated to one through the table size.
    always_comb begin
        if (r_table_slots == '0) begin
            w_slots = scht_pkg::SLOTS_W'(1);
        end else if (32'(r_table_slots) > scht_pkg::TABLE_SIZE) begin
            w_slots = scht_pkg::SLOTS_W'(scht_pkg::TABLE_SIZE);
        end else begin
            w_slots = scht_pkg::SLOTS_W'(r_table_slots);
        end
    end

    scht_front u_front (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_in_valid(i_in_valid),
        .o_in_stall(o_in_stall),
        .i_in_data (i_in_data),
        .i_slots   (w_slots),
        .o_push    (w_push),
        .o_ent     (w_f_ent),
        .i_full    (w_full)
    );

    scht_queue u_queue (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_push (w_push),
        .i_ent  (w_f_ent),
        .o_full (w_full),
        .i_pop  (w_pop),
        .o_valid(w_q_valid),
        .o_ent  (w_q_ent)
    );

    scht_back u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_q_valid  (w_q_valid),
        .i_q_ent    (w_q_ent),
        .o_q_pop    (w_pop),
        .i_slots    (w_slots),
        .o_out_valid(o_out_valid),
        .i_out_stall(i_out_stall),
        .o_out_data (o_out_data)
    );

    // The front never pushes into a full queue.
    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_push |-> !w_full) else $error("push into full queue");

    // The back never pops an empty queue.
    a_no_underflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_pop |-> w_q_valid) else $error("pop from empty queue");

    // A cleared or not-found result is a single final result with id zero.
    a_single_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && (o_out_data.status == scht_pkg::ST_CLEARED ||
                         o_out_data.status == scht_pkg::ST_NOTFOUND))
        |-> (o_out_data.last && o_out_data.member_id == 16'd0))
        else $error("bad single result");

    // After a push the front is idle again and can take a new item.
    a_take_after_push: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_push |=> !o_in_stall) else $error("front not free after push");

endmodule
